// ----- design/skf_pkg.sv -----
// shared constants and types for the sortable integer key formatter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package skf_pkg;

    localparam int KEY_DIGITS = 19;
    localparam int KEY_LEN    = KEY_DIGITS + 1;
    localparam int VAL_W      = 64;
    localparam int BCD_W      = 4 * KEY_DIGITS;
    localparam int POS_W      = 5;
    localparam int STEP_BITS  = 8;
    localparam int N_STAGES   = VAL_W / STEP_BITS;
    localparam int OUT_W      = 16;

    localparam logic [7:0] CHAR_NEG  = 8'h6E;  // 'n'
    localparam logic [7:0] CHAR_ZERO = 8'h6F;  // 'o'
    localparam logic [7:0] CHAR_POS  = 8'h70;  // 'p'
    localparam logic [3:0] DIGIT_HI  = 4'h3;   // upper nibble of ascii '0'..'9'

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(KEY_LEN - 1);

    typedef struct packed {
        logic [7:0]       prefix;
        logic [VAL_W-1:0] mag;
        logic [BCD_W-1:0] bcd;
    } t_conv;

endpackage

// ----- design/skf_dabble_stage.sv -----
// one pipeline stage of the binary to bcd converter: STEP_BITS shift-add-3 steps
// depends on skf_pkg
`timescale 1ns / 1ps

module skf_dabble_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  skf_pkg::t_conv i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output skf_pkg::t_conv o_data
);
    import skf_pkg::*;

    logic  r_valid;
    t_conv r_data;
    t_conv n_data;

    function automatic logic [BCD_W-1:0] dabble_step(logic [BCD_W-1:0] bcd, logic bit_in);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < KEY_DIGITS; d++) begin
            if (adj[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    always_comb begin
        n_data = i_data;
        for (int s = 0; s < STEP_BITS; s++) begin
            n_data.bcd = dabble_step(n_data.bcd, n_data.mag[VAL_W-1]);
            n_data.mag = {n_data.mag[VAL_W-2:0], 1'b0};
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- design/skf_serializer.sv -----
// holds one finished key and sends it out one byte per transfer, prefix first
// depends on skf_pkg
`timescale 1ns / 1ps

module skf_serializer (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [7:0]               i_prefix,
    input  logic [skf_pkg::BCD_W-1:0] i_bcd,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [skf_pkg::OUT_W-1:0] m_axis_tdata,  // [7:0] key_char, [12:8] position
    output logic                     m_axis_tlast
);
    import skf_pkg::*;

    logic             r_busy;
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_pfx;
    logic [BCD_W-1:0] r_bcd;
    logic             take;
    logic             at_last;
    logic             load;
    logic [7:0]       key_char;

    assign take    = r_busy && m_axis_tready;
    assign at_last = (r_pos == POS_LAST);
    assign o_ready = !r_busy || (take && at_last);
    assign load    = o_ready && i_valid;

    assign key_char      = (r_pos == '0) ? r_pfx : {DIGIT_HI, r_bcd[BCD_W-1 -: 4]};
    assign m_axis_tvalid = r_busy;
    assign m_axis_tlast  = at_last;
    assign m_axis_tdata  = {(OUT_W - POS_W - 8)'(0), r_pos, key_char};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_pos  <= '0;
        end else if (take) begin
            r_busy <= !at_last;
            r_pos  <= r_pos + 1'b1;
        end
    end

    // digits move up one nibble after each digit transfer
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pfx <= i_prefix;
            r_bcd <= i_bcd;
        end else if (take && r_pos != '0) begin
            r_bcd <= {r_bcd[BCD_W-5:0], 4'h0};
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pos <= POS_LAST))
        else $error("key position beyond last byte");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !at_last) |=> (r_busy && r_pos == $past(r_pos) + 5'd1))
        else $error("key position did not advance");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !m_axis_tready) |=> (r_busy && $stable(r_pos) && $stable(r_bcd)))
        else $error("key changed while stalled");

    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_busy && r_pos == '0))
        else $error("new key did not start at prefix");

endmodule

// ----- design/sortable_integer_key_format.sv -----
// Sortable integer key formatter, top level.
// Depends on skf_pkg, skf_dabble_stage and skf_serializer.
//
// Input channel s_axis carries one signed 64-bit integer per transfer.
// Output channel m_axis carries the 20-byte key one byte per transfer:
// a sign prefix 'n', 'o' or 'p', then 19 zero-padded decimal digits of the
// magnitude field (v + 2^63 for negative v), most significant first.
// Each byte carries its position 0..19; tlast marks position 19.
// The first key byte is valid once the input has passed the sign stage (it
// registers at the transfer), eight conversion stages of 8 double-dabble
// steps each and the serializer load. The one-byte output channel sets the
// rate of integers; the conversion stages take a new item every cycle while
// the stage ahead can accept it, and the sign and conversion stages hold up
// to nine items while the serializer drains a key.
// Reset clears all valid bits and the serializer; no key is in flight after.
// When the receiver stalls, the current byte holds and the stages fill,
// then s_axis_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps

module sortable_integer_key_format (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [skf_pkg::VAL_W-1:0] s_axis_tdata,   // [63:0] value
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [skf_pkg::OUT_W-1:0] m_axis_tdata,   // [7:0] key_char, [12:8] position
    output logic                      m_axis_tlast
);
    import skf_pkg::*;

    logic  w_vld [0:N_STAGES];
    logic  w_rdy [0:N_STAGES];
    t_conv w_dat [0:N_STAGES];

    logic  r_v0;
    t_conv r_d0;
    t_conv n_d0;

    // sign stage: the magnitude field is always the low 63 bits
    always_comb begin
        n_d0.mag = {1'b0, s_axis_tdata[VAL_W-2:0]};
        n_d0.bcd = '0;
        priority if (s_axis_tdata[VAL_W-1]) begin
            n_d0.prefix = CHAR_NEG;
        end else if (s_axis_tdata != '0) begin
            n_d0.prefix = CHAR_POS;
        end else begin
            n_d0.prefix = CHAR_ZERO;
        end
    end

    assign s_axis_tready = !r_v0 || w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (s_axis_tready) begin
            r_v0 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_d0 <= n_d0;
        end
    end

    assign w_vld[0] = r_v0;
    assign w_dat[0] = r_d0;

    for (genvar g = 0; g < N_STAGES; g++) begin : g_stage
        skf_dabble_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g]),
            .o_ready (w_rdy[g]),
            .i_data  (w_dat[g]),
            .o_valid (w_vld[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_data  (w_dat[g+1])
        );
    end

    skf_serializer u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_vld[N_STAGES]),
        .o_ready       (w_rdy[N_STAGES]),
        .i_prefix      (w_dat[N_STAGES].prefix),
        .i_bcd         (w_dat[N_STAGES].bcd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- tb/tb_sortable_integer_key_format.sv -----
// testbench for sortable_integer_key_format: drives signed 64-bit values, predicts
// the 20-byte order-preserving key of each one and checks every output byte
// depends on skf_pkg and the sortable_integer_key_format top level
`timescale 1ns / 1ps

module tb_sortable_integer_key_format;

    import skf_pkg::*;

    localparam int CYCLE_LIMIT = 300_000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [7:0]       key_char;
        logic [POS_W-1:0] position;
        logic             last;
    } t_key_byte;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [VAL_W-1:0]   s_axis_tdata = '0;     // [63:0] value
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;          // [7:0] key_char, [12:8] position
    logic               m_axis_tlast;

    t_key_byte key_bytes_due[$];
    t_key_byte key_byte_want;
    int        mismatches = 0;
    int        cycle_count = 0;
    bit        tx_idle_en = 1'b1;
    bit        rx_idle_en = 1'b1;
    int        hold_requests = 0;
    int        hold_served = 0;
    int        hold_left = 0;

    sortable_integer_key_format i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // expected key bytes for one integer, queued in output order
    function automatic void predict_key(input logic [VAL_W-1:0] value);
        logic [VAL_W-1:0] mag;
        logic [7:0]       chars [KEY_LEN];
        t_key_byte        kb;
        if (value[VAL_W-1]) begin
            chars[0] = CHAR_NEG;
            mag = {1'b0, value[VAL_W-2:0]};    // v + 2^63
        end else if (value != '0) begin
            chars[0] = CHAR_POS;
            mag = value;
        end else begin
            chars[0] = CHAR_ZERO;
            mag = '0;
        end
        for (int k = KEY_DIGITS; k >= 1; k--) begin
            chars[k] = {DIGIT_HI, 4'(mag % 64'd10)};
            mag = mag / 64'd10;
        end
        for (int k = 0; k < KEY_LEN; k++) begin
            kb.key_char = chars[k];
            kb.position = POS_W'(k);
            kb.last     = (k == KEY_LEN - 1);
            key_bytes_due.push_back(kb);
        end
    endfunction

    // input monitor
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_key(s_axis_tdata);
        end
    end

    // output checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (key_bytes_due.size() == 0) begin
                $error("unexpected key byte: key_char %h position %0d last %b",
                       m_axis_tdata[7:0], m_axis_tdata[12:8], m_axis_tlast);
                mismatches++;
            end else begin
                key_byte_want = key_bytes_due.pop_front();
                if (m_axis_tdata[7:0] !== key_byte_want.key_char) begin
                    $error("key_char: expected %h actual %h",
                           key_byte_want.key_char, m_axis_tdata[7:0]);
                    mismatches++;
                end
                if (m_axis_tdata[12:8] !== key_byte_want.position) begin
                    $error("position: expected %0d actual %0d",
                           key_byte_want.position, m_axis_tdata[12:8]);
                    mismatches++;
                end
                if (m_axis_tlast !== key_byte_want.last) begin
                    $error("last: expected %b actual %b", key_byte_want.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // receiver: random stalls, or a long hold when one is requested
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_en) begin
            m_axis_tready <= ($urandom_range(99) >= 34);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sortable_integer_key_format: mismatch");
            $finish;
        end
    end

    // called and returns at a falling edge
    task automatic send_value(input logic [VAL_W-1:0] value);
        while (tx_idle_en && $urandom_range(99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] random_value();
        logic [VAL_W-1:0] v;
        logic [VAL_W-1:0] p;
        case ($urandom_range(3))
            0: v = {$urandom, $urandom};
            1: begin
                v = VAL_W'($urandom_range(1000));
                if ($urandom_range(1)) v = -v;
            end
            2: begin
                if ($urandom_range(1)) v = 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(50);
                else v = 64'h8000_0000_0000_0000 + $urandom_range(50);
            end
            default: begin
                // magnitude near a power of ten, either sign
                p = 64'd1;
                repeat ($urandom_range(18)) p = p * 64'd10;
                v = p + $urandom_range(2) - 1;
                if ($urandom_range(1)) v = {1'b1, v[VAL_W-2:0]};
            end
        endcase
        return v;
    endfunction

    task automatic test_directed();
        logic [VAL_W-1:0] values [] = '{
            64'd0, 64'd1, -64'd1, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
            64'h8000_0000_0000_0001, -64'd2, 64'd9, 64'd10, 64'd999_999_999_999_999_999,
            64'd1_000_000_000_000_000_000, -64'd1_000_000_000_000_000_000,
            64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'h0000_0000_FFFF_FFFF,
            64'h0000_0001_0000_0000, 64'h8000_0000_0000_0009, 64'h8000_0000_0000_000A
        };
        foreach (values[i]) send_value(values[i]);
    endtask

    task automatic test_random(input int count);
        repeat (count) send_value(random_value());
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        hold_requests++;
        @(negedge i_clk);
        repeat (40) send_value(random_value());
        tx_idle_en = 1'b1;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random(350);

        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random(100);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        test_backpressure();
        s_axis_tvalid <= 1'b0;

        while (key_bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("sortable_integer_key_format: match");
        end else begin
            $display("sortable_integer_key_format: mismatch");
        end
        $finish;
    end

endmodule
